>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a named clock and active-low reset
`define ASSERT_AT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// concurrent check on the block clock and reset
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk, rst_n, prop, msg)

`endif

>>> hw/rtl/clc_pkg.sv
package clc_pkg;

  localparam int unsigned REQ_W   = 4;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SECS_W  = 22;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [THR_W-1:0] THR_RESET = 16'd60;

  localparam logic [REQ_W-1:0] REQ_TICK        = 4'd0;
  localparam logic [REQ_W-1:0] REQ_START       = 4'd1;
  localparam logic [REQ_W-1:0] REQ_RESUME_SECS = 4'd2;
  localparam logic [REQ_W-1:0] REQ_FORCE_LOCK  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_STOP        = 4'd4;
  localparam logic [REQ_W-1:0] REQ_PAUSE       = 4'd5;
  localparam logic [REQ_W-1:0] REQ_RESUME      = 4'd6;
  localparam logic [REQ_W-1:0] REQ_UNLOCKING   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_UNLOCK_RPT  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_LOCKOUT     = 4'd9;

  localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COUNTING   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WARNING    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCKED     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNLOCKING  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UNLOCKED   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LOCKED_OUT = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SECS_W-1:0] secs;
    logic              run;
  } state_t;

  typedef struct packed {
    logic second_shown;
    logic warning_tick;
    logic warning_started;
    logic lock_activated;
    logic lockout_started;
    logic unlock_succeeded;
    logic unlock_failed;
    logic mode_changed;
  } flags_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [AMT_W-1:0] amount;
    logic             unlock_ok;
  } item_t;

endpackage

>>> hw/rtl/clc_event.sv
module clc_event (
  input  clc_pkg::item_t                  item,
  input  clc_pkg::state_t                 st_cur,
  input  logic [clc_pkg::THR_W-1:0]       thr,
  output clc_pkg::state_t                 st_nxt,
  output clc_pkg::flags_t                 flg
);
  import clc_pkg::*;

  logic [SECS_W-1:0] dec;
  logic [SECS_W-1:0] start_secs;
  logic              unl_forced;

  // minutes times 60 as 64x - 4x
  assign start_secs = {item.amount, 6'd0} - {4'd0, item.amount, 2'd0};
  assign dec        = st_cur.secs - 22'd1;

  always_comb begin
    st_nxt     = st_cur;
    flg        = '0;
    unl_forced = 1'b0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (st_cur.run) begin
          if (st_cur.secs != '0) begin
            st_nxt.secs = dec;
            if (st_cur.mode == MODE_COUNTING) begin
              flg.second_shown = 1'b1;
              if (dec <= {6'd0, thr}) begin
                st_nxt.mode         = MODE_WARNING;
                flg.warning_started = 1'b1;
                flg.warning_tick    = 1'b1;
              end
            end else if (st_cur.mode == MODE_WARNING) begin
              flg.warning_tick = 1'b1;
              flg.second_shown = 1'b1;
              if (dec == '0) begin
                st_nxt.run         = 1'b0;
                st_nxt.mode        = MODE_LOCKED;
                flg.lock_activated = 1'b1;
              end
            end else if (st_cur.mode == MODE_LOCKED_OUT) begin
              if (dec == '0) begin
                st_nxt.run  = 1'b0;
                st_nxt.mode = MODE_LOCKED;
              end
            end
          end else begin
            st_nxt.run = 1'b0;
          end
        end
      end
      REQ_START: begin
        st_nxt.secs      = start_secs;
        st_nxt.mode      = MODE_COUNTING;
        st_nxt.run       = 1'b1;
        flg.second_shown = 1'b1;
      end
      REQ_RESUME_SECS: begin
        st_nxt.secs      = {6'd0, item.amount};
        st_nxt.mode      = MODE_COUNTING;
        st_nxt.run       = 1'b1;
        flg.second_shown = 1'b1;
      end
      REQ_FORCE_LOCK: begin
        st_nxt.run         = 1'b0;
        st_nxt.secs        = '0;
        st_nxt.mode        = MODE_LOCKED;
        flg.lock_activated = 1'b1;
      end
      REQ_STOP: begin
        st_nxt.run  = 1'b0;
        st_nxt.mode = MODE_IDLE;
      end
      REQ_PAUSE: begin
        st_nxt.run = 1'b0;
      end
      REQ_RESUME: begin
        if (st_cur.mode != MODE_IDLE) begin
          st_nxt.run = 1'b1;
        end
      end
      REQ_UNLOCKING: begin
        st_nxt.mode = MODE_UNLOCKING;
      end
      REQ_UNLOCK_RPT: begin
        if (item.unlock_ok) begin
          // mode_changed is flagged here even if the mode was already idle
          st_nxt.mode          = MODE_IDLE;
          st_nxt.run           = 1'b0;
          flg.unlock_succeeded = 1'b1;
          unl_forced           = 1'b1;
        end else begin
          flg.unlock_failed = 1'b1;
        end
      end
      REQ_LOCKOUT: begin
        st_nxt.secs         = {6'd0, item.amount};
        st_nxt.mode         = MODE_LOCKED_OUT;
        st_nxt.run          = 1'b1;
        flg.lockout_started = 1'b1;
      end
      default: begin
      end
    endcase
    flg.mode_changed = unl_forced || (st_nxt.mode != st_cur.mode);
  end

endmodule

>>> hw/rtl/countdown_lock_controller_top.sv
// an accepted input word is held in the input register, its result in the output register
// throughput: one word per cycle unless out_tready stalls; next state is combinational
// input stalls only while both registers hold a word and out_tready is low
// reset (rst_n low, synchronous): mode idle, count zero, not running,
// warning threshold 60, both stages empty
`include "assert_macros.svh"

module countdown_lock_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clc_pkg::THR_W-1:0]           cfg_data,   // warning_threshold
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clc_pkg::IN_TDATA_W-1:0]      in_tdata,   // amount, unlock_ok, zero pad
  input  logic [clc_pkg::REQ_W-1:0]           in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // mode, remaining, running, second_shown, warning_tick, warning_started,
  // lock_activated, lockout_started, unlock_succeeded, unlock_failed,
  // mode_changed, zero pad
  output logic [clc_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import clc_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             in_vld_r;
  item_t            item_r;
  state_t           st_r;
  state_t           st_nxt;
  flags_t           flg;
  logic             out_vld_r;
  state_t           out_st_r;
  flags_t           out_flg_r;
  logic             adv;
  logic             fire;

  assign cfg_ready = 1'b1;
  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type  <= in_tuser;
      item_r.amount    <= in_tdata[AMT_W-1:0];
      item_r.unlock_ok <= in_tdata[AMT_W];
    end
  end

  clc_event u_event (
    .item   (item_r),
    .st_cur (st_r),
    .thr    (thr_r),
    .st_nxt (st_nxt),
    .flg    (flg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= MODE_IDLE;
      st_r.secs <= '0;
      st_r.run  <= 1'b0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_st_r  <= st_nxt;
      out_flg_r <= flg;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0,
                       out_flg_r.mode_changed,
                       out_flg_r.unlock_failed,
                       out_flg_r.unlock_succeeded,
                       out_flg_r.lockout_started,
                       out_flg_r.lock_activated,
                       out_flg_r.warning_started,
                       out_flg_r.warning_tick,
                       out_flg_r.second_shown,
                       out_st_r.run,
                       out_st_r.secs,
                       out_st_r.mode};

  `ASSERT_CLK(a_state_hold, !fire |=> $stable(st_r), "state changed without an item")
  `ASSERT_CLK(a_stall_cause, !in_tready |-> (in_vld_r && out_vld_r && !out_tready),
              "input stalled without a blocked result")
  `ASSERT_CLK(a_lock_flags, (out_vld_r && out_flg_r.lock_activated) |->
              (out_st_r.mode == MODE_LOCKED && !out_st_r.run && out_st_r.secs == '0),
              "lock activation with inconsistent state")
  `ASSERT_CLK(a_warn_flags, (out_vld_r && out_flg_r.warning_started) |->
              (out_st_r.mode == MODE_WARNING && out_flg_r.warning_tick),
              "warning start with inconsistent state")
  `ASSERT_CLK(a_out_matches_state, (out_vld_r && $past(fire)) |-> (out_st_r == st_r),
              "result word differs from held state")

endmodule
